@@ hdl/ascii_decimal_to_fixed_macros.svh @@
// ---------------------------------------------------------------------------
// ascii_decimal_to_fixed_macros
// Assertion helpers shared by the converter modules; clocked on clock,
// disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASCII_DECIMAL_TO_FIXED_MACROS_SVH
`define ASCII_DECIMAL_TO_FIXED_MACROS_SVH

// Property holds at every edge outside reset.
`define ADTF_ASSERT_HOLDS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ADTF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/adtf_pkg.sv @@
// ---------------------------------------------------------------------------
// adtf_pkg
// Shared constants, the parsed-string record and the power-of-ten table.
// ---------------------------------------------------------------------------
package adtf_pkg;

   // default configuration
   localparam int FRAC_BITS_DEF   = 24;
   localparam int FRAC_DIGITS_DEF = 7;
   localparam int EXP_CAP_DEF     = 20;
   localparam int QUEUE_DEPTH_DEF = 2;

   // widths sized for the whole parameter range
   localparam int BASE_MAX_W = 60;   // integer part, FRAC_BITS >= 4
   localparam int FRAC_MAX_W = 30;   // up to nine kept fraction digits
   localparam int FCNT_W     = 4;
   localparam int EXP_W      = 5;

   // character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_UE    = 8'h45;
   localparam logic [7:0] CH_LE    = 8'h65;

   // parser phases
   localparam logic [2:0] PH_LEAD    = 3'd0;
   localparam logic [2:0] PH_INT     = 3'd1;
   localparam logic [2:0] PH_FRAC    = 3'd2;
   localparam logic [2:0] PH_EXP     = 3'd3;
   localparam logic [2:0] PH_EXP_DOT = 3'd4;
   localparam logic [2:0] PH_FROZEN  = 3'd5;

   // one parsed string, handed from parser to scaler
   typedef struct packed {
      logic                  neg;
      logic                  ovf;
      logic [BASE_MAX_W-1:0] base;
      logic [FRAC_MAX_W-1:0] frac;
      logic [FCNT_W-1:0]     fcnt;
      logic [EXP_W-1:0]      expo;
   } job_type;

   function automatic logic [FRAC_MAX_W-1:0] pow10(input logic [FCNT_W-1:0] n);
      logic [FRAC_MAX_W-1:0] p;
      unique case (n)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = 30'd1;
      endcase
      return p;
   endfunction

endpackage

@@ hdl/adtf_front.sv @@
// ---------------------------------------------------------------------------
// adtf_front
// Parser: one char per cycle unless the queue is full; one record per string.
// ---------------------------------------------------------------------------
module adtf_front
   import adtf_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
   parameter int EXP_CAP     = EXP_CAP_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_code,
   input  logic       req_last_char,
   input  logic       csr_write_en,
   input  logic       csr_write_data,
   output logic       job_push,
   output job_type    job_data,
   input  logic       job_full
);

   localparam int BASE_W = 64 - FRAC_BITS;
   localparam int FRAC_W = $clog2(10 ** FRAC_DIGITS);
   localparam logic [BASE_W-1:0] BASE_LIM = {1'b1, {(BASE_W-1){1'b0}}};

   logic              exp_en_ff;
   logic [2:0]        phase_ff, phase_in;
   logic              neg_ff, neg_in;
   logic              ovf_ff, ovf_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [FCNT_W-1:0] fcnt_ff, fcnt_in;
   logic [EXP_W-1:0]  expo_ff, expo_in;

   logic              accept, str_end, is_digit, is_exp, do_int;
   logic [3:0]        digit;
   logic [BASE_W+3:0] base_nv;
   logic [FRAC_W+3:0] frac_nv;
   logic [EXP_W+3:0]  expo_nv;

   assign req_full = job_full;
   assign accept   = req_push && !req_full;
   assign str_end  = (req_char_code == CH_NUL) || req_last_char;
   assign job_push = accept && str_end;
   assign is_digit = (req_char_code >= CH_0) && (req_char_code <= CH_9);
   assign digit    = req_char_code[3:0];
   assign is_exp   = exp_en_ff && ((req_char_code == CH_LE) || (req_char_code == CH_UE));

   assign base_nv = ({4'b0, base_ff} << 3) + ({4'b0, base_ff} << 1) + (BASE_W+4)'(digit);
   assign frac_nv = ({4'b0, frac_ff} << 3) + ({4'b0, frac_ff} << 1) + (FRAC_W+4)'(digit);
   assign expo_nv = ({4'b0, expo_ff} << 3) + ({4'b0, expo_ff} << 1) + (EXP_W+4)'(digit);

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      base_in  = base_ff;
      frac_in  = frac_ff;
      fcnt_in  = fcnt_ff;
      expo_in  = expo_ff;
      do_int   = 1'b0;

      if (accept && (req_char_code != CH_NUL)) begin
         unique case (phase_ff)
            PH_LEAD: begin
               if (req_char_code != CH_SP) begin
                  phase_in = PH_INT;
                  if (req_char_code == CH_MINUS) begin
                     neg_in = 1'b1;
                  end else if (req_char_code != CH_PLUS) begin
                     do_int = 1'b1;
                  end
               end
            end
            PH_INT: begin
               do_int = 1'b1;
            end
            PH_FRAC: begin
               if (is_digit) begin
                  if (fcnt_ff < FCNT_W'(FRAC_DIGITS)) begin
                     frac_in = frac_nv[FRAC_W-1:0];
                     fcnt_in = fcnt_ff + 1'b1;
                  end
               end else if (is_exp) begin
                  phase_in = PH_EXP_DOT;
               end else begin
                  phase_in = PH_FROZEN;
               end
            end
            PH_EXP, PH_EXP_DOT: begin
               if (is_digit) begin
                  if (expo_nv > (EXP_W+4)'(EXP_CAP)) begin
                     expo_in = EXP_W'(EXP_CAP);
                  end else begin
                     expo_in = expo_nv[EXP_W-1:0];
                  end
               end else if (phase_ff == PH_EXP) begin
                  phase_in = PH_FROZEN;
               end
            end
            default: begin
            end
         endcase

         if (do_int) begin
            priority if (is_digit) begin
               if (!ovf_ff) begin
                  if (base_nv > (BASE_W+4)'(BASE_LIM)) begin
                     ovf_in = 1'b1;
                  end else begin
                     base_in = base_nv[BASE_W-1:0];
                  end
               end
            end else if (req_char_code == CH_DOT) begin
               phase_in = PH_FRAC;
            end else if (is_exp) begin
               phase_in = PH_EXP;
            end else begin
               phase_in = PH_FROZEN;
            end
         end
      end

      job_data.neg  = neg_in;
      job_data.ovf  = ovf_in;
      job_data.base = BASE_MAX_W'(base_in);
      job_data.frac = FRAC_MAX_W'(frac_in);
      job_data.fcnt = fcnt_in;
      job_data.expo = expo_in;

      if (job_push) begin
         phase_in = PH_LEAD;
         neg_in   = 1'b0;
         ovf_in   = 1'b0;
         base_in  = '0;
         frac_in  = '0;
         fcnt_in  = '0;
         expo_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_en_ff <= 1'b1;
         phase_ff  <= PH_LEAD;
         neg_ff    <= 1'b0;
         ovf_ff    <= 1'b0;
         base_ff   <= '0;
         frac_ff   <= '0;
         fcnt_ff   <= '0;
         expo_ff   <= '0;
      end else begin
         if (csr_write_en) begin
            exp_en_ff <= csr_write_data;
         end
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         ovf_ff   <= ovf_in;
         base_ff  <= base_in;
         frac_ff  <= frac_in;
         fcnt_ff  <= fcnt_in;
         expo_ff  <= expo_in;
      end
   end

endmodule

@@ hdl/adtf_queue.sv @@
// ---------------------------------------------------------------------------
// adtf_queue
// Short register queue of parsed strings between parser and scaler.
// ---------------------------------------------------------------------------
`include "ascii_decimal_to_fixed_macros.svh"

module adtf_queue
   import adtf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type wr_data,
   output logic    full,
   input  logic    pop,
   output job_type rd_data,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         unique case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   `ADTF_ASSERT_NEXT(a_push_fills, do_push && !do_pop, !empty, "queue lost a word")
   `ADTF_ASSERT_NEXT(a_last_pop, do_pop && !do_push && count_ff == CNT_W'(1), empty, "queue count")
   `ADTF_ASSERT_HOLDS(a_count_range, count_ff <= CNT_W'(DEPTH), "queue count past depth")

endmodule

@@ hdl/adtf_back.sv @@
// ---------------------------------------------------------------------------
// adtf_back
// Scaler: applies exponent and fraction to a parsed string, rounds,
// saturates and holds the result for the output side.
// ---------------------------------------------------------------------------
`include "ascii_decimal_to_fixed_macros.svh"

module adtf_back
   import adtf_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_empty,
   output logic               job_pop,
   input  job_type            job_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [63:0] rsp_value,
   output logic               rsp_saturated
);

   localparam int BASE_W = 64 - FRAC_BITS;
   localparam int FRAC_W = $clog2(10 ** FRAC_DIGITS);
   localparam int NUM_W  = FRAC_W + FRAC_BITS;
   localparam int DCNT_W = $clog2(NUM_W + 1);
   localparam int CNT_W  = (DCNT_W > EXP_W) ? DCNT_W : EXP_W;
   localparam logic [BASE_W-1:0] BASE_LIM = {1'b1, {(BASE_W-1){1'b0}}};
   localparam logic [63:0] LIM_NEG = {1'b1, {63{1'b0}}};
   localparam logic [63:0] LIM_POS = {1'b0, {63{1'b1}}};
   localparam logic [NUM_W-1:0] FU_MAX = NUM_W'(1) << FRAC_BITS;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXP    = 3'd1;
   localparam logic [2:0] ST_FSCALE = 3'd2;
   localparam logic [2:0] ST_DIV1   = 3'd3;
   localparam logic [2:0] ST_DIV2   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]         st_ff, st_in;
   logic               neg_ff, neg_in;
   logic               sat_ff, sat_in;
   logic [BASE_W-1:0]  ip_ff, ip_in;
   logic [BASE_W-1:0]  fi_ff, fi_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [FCNT_W-1:0]  f_ff, f_in;
   logic [EXP_W-1:0]   e_ff, e_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [FRAC_W-1:0]  den_ff, den_in;
   logic [FRAC_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [FRAC_BITS:0] fu_ff, fu_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [63:0] value_ff, value_in;
   logic               sat_out_ff, sat_out_in;

   logic [BASE_W-1:0]  ib, job_ib;
   logic [BASE_W+3:0]  ip_x10, fi_x10;
   logic [BASE_W:0]    ip_plus_fi, ip_plus_q;
   logic [FRAC_W:0]    rem_sh;
   logic               div_ge;
   logic [63:0]        mag, lim, mag_f;
   logic               over, slot_free;
   logic               in_div, round_last, sat_word, at_limit;

   assign ib         = neg_ff ? BASE_LIM : BASE_LIM - 1'b1;
   assign job_ib     = job_data.neg ? BASE_LIM : BASE_LIM - 1'b1;
   assign ip_x10     = ({4'b0, ip_ff} << 3) + ({4'b0, ip_ff} << 1);
   assign fi_x10     = ({4'b0, fi_ff} << 3) + ({4'b0, fi_ff} << 1);
   assign ip_plus_fi = {1'b0, ip_ff} + {1'b0, fi_ff};
   assign ip_plus_q  = {1'b0, ip_ff} + (BASE_W+1)'(quo_ff[FRAC_W-1:0]);
   // one restoring-division step per cycle
   assign rem_sh     = {rem_ff, num_ff[NUM_W-1]};
   assign div_ge     = rem_sh >= {1'b0, den_ff};

   assign mag       = {ip_ff, {FRAC_BITS{1'b0}}} + 64'(fu_ff);
   assign lim       = neg_ff ? LIM_NEG : LIM_POS;
   assign over      = sat_ff || (mag > lim);
   assign mag_f     = over ? lim : mag;
   assign slot_free = !rsp_valid_ff || rsp_pop;

   always_comb begin
      st_in        = st_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      ip_in        = ip_ff;
      fi_in        = fi_ff;
      frac_in      = frac_ff;
      f_in         = f_ff;
      e_in         = e_ff;
      cnt_in       = cnt_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      quo_in       = quo_ff;
      fu_in        = fu_ff;
      job_pop      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      value_in     = value_ff;
      sat_out_in   = sat_out_ff;

      unique case (st_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               neg_in  = job_data.neg;
               ip_in   = job_data.base[BASE_W-1:0];
               frac_in = job_data.frac[FRAC_W-1:0];
               f_in    = job_data.fcnt;
               e_in    = job_data.expo;
               sat_in  = job_data.ovf || (job_data.base[BASE_W-1:0] > job_ib);
               cnt_in  = CNT_W'(job_data.expo);
               fu_in   = '0;
               st_in   = ST_EXP;
            end
         end
         ST_EXP: begin
            if ((cnt_ff == '0) || sat_ff) begin
               priority if (sat_ff) begin
                  st_in = ST_DONE;
               end else if (e_ff >= EXP_W'(f_ff)) begin
                  fi_in  = BASE_W'(frac_ff);
                  cnt_in = CNT_W'(e_ff - EXP_W'(f_ff));
                  st_in  = ST_FSCALE;
               end else begin
                  den_in = FRAC_W'(pow10(f_ff - FCNT_W'(e_ff)));
                  num_in = {frac_ff, {FRAC_BITS{1'b0}}};
                  rem_in = '0;
                  quo_in = '0;
                  cnt_in = CNT_W'(FRAC_W);
                  st_in  = ST_DIV1;
               end
            end else begin
               if (ip_x10 > (BASE_W+4)'(ib)) begin
                  sat_in = 1'b1;
               end
               ip_in  = ip_x10[BASE_W-1:0];
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_FSCALE: begin
            if ((cnt_ff == '0) || sat_ff) begin
               if (!sat_ff) begin
                  if (ip_plus_fi > (BASE_W+1)'(ib)) begin
                     sat_in = 1'b1;
                  end
                  ip_in = ip_plus_fi[BASE_W-1:0];
               end
               st_in = ST_DONE;
            end else begin
               if (fi_x10 > (BASE_W+4)'(ib)) begin
                  sat_in = 1'b1;
               end
               fi_in  = fi_x10[BASE_W-1:0];
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DIV1, ST_DIV2: begin
            if (cnt_ff == '0) begin
               if (st_ff == ST_DIV1) begin
                  // integer share of the fraction, then round the remainder
                  if (ip_plus_q > (BASE_W+1)'(ib)) begin
                     sat_in = 1'b1;
                     st_in  = ST_DONE;
                  end else begin
                     st_in = ST_DIV2;
                  end
                  ip_in  = ip_plus_q[BASE_W-1:0];
                  num_in = {rem_ff, {FRAC_BITS{1'b0}}} + NUM_W'(den_ff >> 1);
                  rem_in = '0;
                  quo_in = '0;
                  cnt_in = CNT_W'(NUM_W);
               end else begin
                  fu_in = quo_ff[FRAC_BITS:0];
                  st_in = ST_DONE;
               end
            end else begin
               rem_in = div_ge ? FRAC_W'(rem_sh - {1'b0, den_ff}) : rem_sh[FRAC_W-1:0];
               quo_in = {quo_ff[NUM_W-2:0], div_ge};
               num_in = num_ff << 1;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               value_in     = neg_ff ? -mag_f : mag_f;
               sat_out_in   = over;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      neg_ff     <= neg_in;
      sat_ff     <= sat_in;
      ip_ff      <= ip_in;
      fi_ff      <= fi_in;
      frac_ff    <= frac_in;
      f_ff       <= f_in;
      e_ff       <= e_in;
      cnt_ff     <= cnt_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      num_ff     <= num_in;
      quo_ff     <= quo_in;
      fu_ff      <= fu_in;
      value_ff   <= value_in;
      sat_out_ff <= sat_out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_empty     = !rsp_valid_ff;
   assign rsp_value     = value_ff;
   assign rsp_saturated = sat_out_ff;

   assign in_div     = (st_ff == ST_DIV1) || (st_ff == ST_DIV2);
   assign round_last = (st_ff == ST_DIV2) && (cnt_ff == '0);
   assign sat_word   = !rsp_empty && rsp_saturated;
   assign at_limit   = (rsp_value == LIM_POS) || (rsp_value == LIM_NEG);

   `ADTF_ASSERT_HOLDS(a_rem_below_den, in_div |-> rem_ff < den_ff, "remainder out of range")
   `ADTF_ASSERT_HOLDS(a_round_range, round_last |-> quo_ff <= FU_MAX, "rounded fraction too big")
   `ADTF_ASSERT_HOLDS(a_sat_clamps, sat_word |-> at_limit, "saturated word not clamped")

endmodule

@@ hdl/ascii_decimal_to_fixed.sv @@
// ---------------------------------------------------------------------------
// ascii_decimal_to_fixed: decimal text to signed fixed point
// Input: one character per cycle; the parser never stalls unless the string queue is full.
// Scaler: multiply-by-ten loops for the exponent and, when e < f (f = kept fraction digits),
//   a bit-serial divider for the fraction; one string in the scaler at a time.
// Reset: synchronous, clears parser, queue and scaler; exponent_enable returns to 1.
// ---------------------------------------------------------------------------
module ascii_decimal_to_fixed
   import adtf_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
   parameter int EXP_CAP     = EXP_CAP_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_char_code,
   input  logic               req_last_char,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [63:0] rsp_value,
   output logic               rsp_saturated,
   input  logic               csr_write_en,
   input  logic               csr_write_data
);

   logic    job_push, job_full, job_pop, job_empty;
   job_type job_wr, job_rd;

   adtf_front #(
      .FRAC_BITS   (FRAC_BITS),
      .FRAC_DIGITS (FRAC_DIGITS),
      .EXP_CAP     (EXP_CAP)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_char_code  (req_char_code),
      .req_last_char  (req_last_char),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .job_push       (job_push),
      .job_data       (job_wr),
      .job_full       (job_full)
   );

   adtf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .wr_data (job_wr),
      .full    (job_full),
      .pop     (job_pop),
      .rd_data (job_rd),
      .empty   (job_empty)
   );

   adtf_back #(
      .FRAC_BITS   (FRAC_BITS),
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_empty     (job_empty),
      .job_pop       (job_pop),
      .job_data      (job_rd),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_value     (rsp_value),
      .rsp_saturated (rsp_saturated)
   );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: ascii_decimal_to_fixed
// Streams decimal text one character per word into the converter. A scoreboard
// parses the same characters and predicts each fixed-point word, which is
// checked against the block's output. Runs directed corner strings, then
// random numbers, broken numbers and noise under both exponent settings.
// ---------------------------------------------------------------------------
module testbench
   import adtf_pkg::*;
();

   typedef logic [7:0] text_type[$];

   typedef struct packed {
      logic signed [63:0] value;
      logic               saturated;
   } fixed_word_type;

   class conversion_checker;
      logic [2:0]     phase;
      bit             negative;
      bit [63:0]      int_part;
      bit [31:0]      frac_part;
      int unsigned    frac_count;
      int unsigned    exp_value;
      bit             overflow;
      bit             exp_enable;
      fixed_word_type expected_words[$];
      int             failures;

      function new();
         exp_enable = 1'b1;
         failures   = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         phase      = PH_LEAD;
         negative   = 1'b0;
         int_part   = '0;
         frac_part  = '0;
         frac_count = 0;
         exp_value  = 0;
         overflow   = 1'b0;
      endfunction

      function void set_exp_enable(bit v);
         exp_enable = v;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CH_0 && c <= CH_9;
      endfunction

      function bit is_exp_mark(logic [7:0] c);
         return exp_enable && (c == CH_LE || c == CH_UE);
      endfunction

      function void add_exp_digit(logic [7:0] c);
         int unsigned t;
         t = exp_value * 10 + int'(c - CH_0);
         exp_value = (t > EXP_CAP_DEF) ? EXP_CAP_DEF : t;
      endfunction

      function void take_integer_char(logic [7:0] c);
         bit [63:0] nv;
         if (is_digit(c)) begin
            if (!overflow) begin
               nv = int_part * 64'd10 + 64'(c - CH_0);
               // integer part is held at most 2^(63-FRAC_BITS)
               if (nv > (64'd1 << (63 - FRAC_BITS_DEF)))
                  overflow = 1'b1;
               else
                  int_part = nv;
            end
         end else if (c == CH_DOT) begin
            phase = PH_FRAC;
         end else if (is_exp_mark(c)) begin
            phase = PH_EXP;
         end else begin
            phase = PH_FROZEN;
         end
      endfunction

      function void parse_char(logic [7:0] c);
         case (phase)
            PH_LEAD: begin
               if (c != CH_SP) begin
                  phase = PH_INT;
                  if (c == CH_MINUS)
                     negative = 1'b1;
                  else if (c != CH_PLUS)
                     take_integer_char(c);
               end
            end
            PH_INT: take_integer_char(c);
            PH_FRAC: begin
               if (is_digit(c)) begin
                  if (frac_count < FRAC_DIGITS_DEF) begin
                     frac_part = frac_part * 10 + 32'(c - CH_0);
                     frac_count++;
                  end
               end else if (is_exp_mark(c)) begin
                  phase = PH_EXP_DOT;
               end else begin
                  phase = PH_FROZEN;
               end
            end
            PH_EXP: begin
               if (is_digit(c))
                  add_exp_digit(c);
               else
                  phase = PH_FROZEN;
            end
            // after a dot, the exponent just skips non-digits
            PH_EXP_DOT: begin
               if (is_digit(c))
                  add_exp_digit(c);
            end
            default: ;
         endcase
      endfunction

      function fixed_word_type finish_string();
         fixed_word_type w;
         bit [63:0]      lim, ib, ip, fi, den, rem, fu, mag;
         bit             sat;
         int unsigned    i;
         lim = negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
         ib  = lim >> FRAC_BITS_DEF;
         ip  = int_part;
         fu  = '0;
         mag = '0;
         sat = overflow || (ip > ib);
         for (i = 0; i < exp_value && !sat; i++) begin
            ip = ip * 64'd10;
            if (ip > ib)
               sat = 1'b1;
         end
         if (!sat) begin
            if (exp_value >= frac_count) begin
               fi = 64'(frac_part);
               for (i = 0; i < exp_value - frac_count && !sat; i++) begin
                  fi = fi * 64'd10;
                  if (fi > ib)
                     sat = 1'b1;
               end
               if (!sat) begin
                  ip = ip + fi;
                  if (ip > ib)
                     sat = 1'b1;
               end
            end else begin
               den = 64'd1;
               for (i = 0; i < frac_count - exp_value; i++)
                  den = den * 64'd10;
               ip  = ip + 64'(frac_part) / den;
               rem = 64'(frac_part) % den;
               // round half away from zero on the magnitude
               fu  = ((rem << FRAC_BITS_DEF) + den / 64'd2) / den;
               if (ip > ib)
                  sat = 1'b1;
            end
         end
         if (!sat) begin
            mag = (ip << FRAC_BITS_DEF) + fu;
            if (mag > lim)
               sat = 1'b1;
         end
         if (sat)
            mag = lim;
         w.value     = negative ? 64'd0 - mag : mag;
         w.saturated = sat;
         clear_parse();
         return w;
      endfunction

      function void note_char(logic [7:0] c, logic last);
         if (c != CH_NUL)
            parse_char(c);
         if (c == CH_NUL || last)
            expected_words.push_back(finish_string());
      endfunction

      function void check_result(logic signed [63:0] value, logic saturated);
         fixed_word_type w;
         if (expected_words.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: unexpected word value=%0d saturated=%0b",
                        $time, value, saturated);
            return;
         end
         w = expected_words.pop_front();
         if (value !== w.value || saturated !== w.saturated) begin
            failures++;
            if (failures <= 10)
               $display("%0t: mismatch value exp=%0d got=%0d, saturated exp=%0b got=%0b",
                        $time, w.value, value, w.saturated, saturated);
         end
      endfunction
   endclass

   localparam int SETTLE_CYCLES = 128;
   localparam int HOLD_CYCLES   = 300;
   localparam int CHARS_PER_RUN = 217;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_push       = 1'b0;
   logic               req_full;
   logic [7:0]         req_char_code  = CH_NUL;
   logic               req_last_char  = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop        = 1'b0;
   logic signed [63:0] rsp_value;
   logic               rsp_saturated;
   logic               csr_write_en   = 1'b0;
   logic               csr_write_data = 1'b0;

   conversion_checker fixed_check;
   bit                send_idle    = 1'b0;
   bit                recv_idle    = 1'b0;
   bit                hold_request = 1'b0;
   int                chars_sent   = 0;

   ascii_decimal_to_fixed dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_char_code  (req_char_code),
      .req_last_char  (req_last_char),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_value      (rsp_value),
      .rsp_saturated  (rsp_saturated),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("[ascii_decimal_to_fixed] ERROR");
      $finish;
   end

   function automatic logic [7:0] rand_digit();
      return CH_0 + 8'($urandom_range(0, 9));
   endfunction

   function automatic text_type random_text();
      text_type t;
      int       kind;
      int       n;
      int       pos;
      bit       dotted;
      kind = $urandom_range(0, 9);
      if (kind == 8) begin
         repeat ($urandom_range(1, 4)) t.push_back(8'($urandom_range(1, 255)));
         return t;
      end
      if (kind == 9) begin
         // empty, sign only, or a long integer run that can pass the limit
         case ($urandom_range(0, 2))
            0: ;
            1: t.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
            default: begin
               if ($urandom_range(0, 1))
                  t.push_back(CH_MINUS);
               repeat ($urandom_range(11, 20)) t.push_back(rand_digit());
            end
         endcase
         return t;
      end
      repeat ($urandom_range(0, 2)) t.push_back(CH_SP);
      case ($urandom_range(0, 2))
         0: t.push_back(CH_MINUS);
         1: t.push_back(CH_PLUS);
         default: ;
      endcase
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 5);
      repeat (n) t.push_back(rand_digit());
      dotted = 1'($urandom_range(0, 1));
      if (dotted) begin
         t.push_back(CH_DOT);
         repeat ($urandom_range(0, 10)) t.push_back(rand_digit());
      end
      if ($urandom_range(0, 2) == 0) begin
         t.push_back($urandom_range(0, 1) ? CH_LE : CH_UE);
         repeat ($urandom_range(0, 2)) begin
            if (dotted && $urandom_range(0, 3) == 0)
               t.push_back(8'($urandom_range(1, 255)));
            t.push_back(rand_digit());
         end
      end
      if (kind == 7) begin
         // broken number: one stray character anywhere
         pos = $urandom_range(0, t.size());
         t.insert(pos, 8'($urandom_range(1, 255)));
      end
      return t;
   endfunction

   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      gap = send_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_char_code <= c;
      req_last_char <= last;
      do @(posedge clock); while (req_full);
      fixed_check.note_char(c, last);
      chars_sent++;
   endtask

   // ends on last_char of the final character, or on a NUL word
   task automatic send_text(input text_type t, input bit nul_end);
      foreach (t[i])
         send_char(t[i], !nul_end && (i == t.size() - 1));
      if (nul_end || t.size() == 0)
         send_char(CH_NUL, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_string(input string s, input bit nul_end);
      text_type t;
      for (int i = 0; i < s.len(); i++)
         t.push_back(s[i]);
      send_text(t, nul_end);
   endtask

   task automatic write_exp_enable(input bit v);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      fixed_check.set_exp_enable(v);
   endtask

   task automatic wait_drained();
      while (fixed_check.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side: per-word random wait when recv_idle is set, plus one long hold on request
   initial begin : result_side
      int pop_wait;
      int hold_left;
      pop_wait  = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            fixed_check.check_result(rsp_value, rsp_saturated);
            pop_wait = recv_idle ? $urandom_range(0, 9) : 0;
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (pop_wait > 0) begin
            pop_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      fixed_check = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < 6; p++) begin
         write_exp_enable(p % 2 == 0);
         send_idle = p inside {0, 1, 3, 5};
         recv_idle = p inside {0, 2, 3, 5};
         if (p == 0) begin
            send_string("", 1'b1);
            send_string("+", 1'b0);
            send_string("-0", 1'b0);
            send_string("--5", 1'b0);
            send_string("- 5", 1'b0);
            send_string("-9e20", 1'b1);
            send_string("1.5e2x3", 1'b0);
            send_string(".5E1", 1'b0);
            send_string("\377", 1'b0);
         end
         if (p == 1)
            send_string("1e3", 1'b0);   // exponent mark is illegal here
         if (p == 2)
            hold_request = 1'b1;        // fill the block and back up the input
         while (chars_sent < (p + 1) * CHARS_PER_RUN)
            send_text(random_text(), $urandom_range(0, 3) == 0);
         req_push <= 1'b0;
         wait_drained();
      end
      if (fixed_check.failures == 0 && fixed_check.pending() == 0)
         $display("[ascii_decimal_to_fixed] OK");
      else
         $display("[ascii_decimal_to_fixed] ERROR");
      $finish;
   end
endmodule
